// ===== hw/rtl/sbsa_pkg.sv =====
// ----------------------------------------------------------------------------
// sbsa_pkg
// Shared widths, codes and memory port structs of the slab slot allocator.
// ----------------------------------------------------------------------------
package sbsa_pkg;

   localparam int SLOTS_PER_CHUNK = 64;
   localparam int NUM_CHUNKS      = 16;
   localparam int SLOT_W          = 6;
   localparam int CHUNK_W         = 4;
   localparam int LINK_W          = 5;

   localparam logic [LINK_W-1:0]          NULL_LINK = LINK_W'(NUM_CHUNKS);
   localparam logic [SLOTS_PER_CHUNK-1:0] FULL_MASK = ~(SLOTS_PER_CHUNK'(0));

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_CHUNK = 2'd1;
   localparam logic [1:0] ST_BAD_FREE = 2'd2;

   typedef logic [SLOTS_PER_CHUNK-1:0] bitmap_type;
   typedef logic [LINK_W-1:0]          link_type;
   typedef logic [CHUNK_W-1:0]         chunk_type;

   typedef struct packed {
      logic       rd_en;
      chunk_type  rd_addr;
      logic       map_we;
      chunk_type  map_addr;
      bitmap_type map_data;
      logic       nxt_we;
      chunk_type  nxt_addr;
      link_type   nxt_data;
      logic       prv_we;
      chunk_type  prv_addr;
      link_type   prv_data;
   } mem_cmd_type;

   typedef struct packed {
      bitmap_type map;
      link_type   nxt;
      link_type   prv;
   } mem_rd_type;

endpackage

// ===== hw/rtl/sbsa_store.sv =====
// ----------------------------------------------------------------------------
// sbsa_store
// Per-chunk free bitmap and list link memories, with registered read data.
// ----------------------------------------------------------------------------
module sbsa_store
   import sbsa_pkg::*;
(
   input  logic        clock,
   input  mem_cmd_type cmd,
   output mem_rd_type  rd
);

   bitmap_type map_mem [NUM_CHUNKS];
   link_type   nxt_mem [NUM_CHUNKS];
   link_type   prv_mem [NUM_CHUNKS];

   bitmap_type map_q_ff;
   link_type   nxt_q_ff;
   link_type   prv_q_ff;

   always_ff @(posedge clock) begin
      if (cmd.map_we) begin
         map_mem[cmd.map_addr] <= cmd.map_data;
      end
      if (cmd.nxt_we) begin
         nxt_mem[cmd.nxt_addr] <= cmd.nxt_data;
      end
      if (cmd.prv_we) begin
         prv_mem[cmd.prv_addr] <= cmd.prv_data;
      end
      if (cmd.rd_en) begin
         map_q_ff <= map_mem[cmd.rd_addr];
         nxt_q_ff <= nxt_mem[cmd.rd_addr];
         prv_q_ff <= prv_mem[cmd.rd_addr];
      end
   end

   assign rd.map = map_q_ff;
   assign rd.nxt = nxt_q_ff;
   assign rd.prv = prv_q_ff;

endmodule

// ===== hw/rtl/sbsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbsa_ctrl
// Request sequencer: chunk choice, bitmap update and list relinking.
// ----------------------------------------------------------------------------
module sbsa_ctrl
   import sbsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [CHUNK_W-1:0] req_chunk_index,
   input  logic [SLOT_W-1:0] req_slot_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [CHUNK_W-1:0] rsp_granted_chunk,
   output logic [SLOT_W-1:0] rsp_granted_slot,
   output logic              rsp_chunk_released,
   output mem_cmd_type       cmd,
   input  mem_rd_type        rd
);

   typedef enum logic [2:0] {S_IDLE, S_READ, S_PUSH, S_PUSH2, S_RESP} state_type;

   state_type              state_ff, state_in;
   logic                   op_ff, op_in;
   chunk_type              chunk_ff, chunk_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic                   claim_ff, claim_in;
   link_type               phead_ff, phead_in;
   link_type               fhead_ff, fhead_in;
   logic [NUM_CHUNKS-1:0]  used_ff, used_in;
   logic                   to_full_ff, to_full_in;
   link_type               old_head_ff, old_head_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   chunk_type              gchunk_ff, gchunk_in;
   logic [SLOT_W-1:0]      gslot_ff, gslot_in;
   logic                   rel_ff, rel_in;

   logic                   req_accept;
   logic                   any_unused;
   chunk_type              low_unused;
   bitmap_type             eff_map;
   logic                   map_found;
   logic [SLOT_W-1:0]      first_bit;
   bitmap_type             slot_mask;
   bitmap_type             new_map;
   logic                   bad_free;
   logic                   map_empty;
   link_type               chunk_link;
   link_type               push_head;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign chunk_link = {1'b0, chunk_ff};

   // lowest unused chunk
   always_comb begin
      any_unused = 1'b0;
      low_unused = '0;
      for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            any_unused = 1'b1;
            low_unused = CHUNK_W'(i);
         end
      end
   end

   // an unused chunk always has an all-free bitmap
   assign eff_map = used_ff[chunk_ff] ? rd.map : FULL_MASK;

   always_comb begin
      map_found = 1'b0;
      first_bit = '0;
      for (int b = SLOTS_PER_CHUNK - 1; b >= 0; b--) begin
         if (eff_map[b]) begin
            map_found = 1'b1;
            first_bit = SLOT_W'(b);
         end
      end
   end

   assign slot_mask = bitmap_type'(1) << ((op_ff == REQ_ALLOC) ? first_bit : slot_ff);
   assign bad_free  = ({1'b0, chunk_ff} >= NULL_LINK)
                   || ({1'b0, slot_ff} >= (SLOT_W+1)'(SLOTS_PER_CHUNK))
                   || !used_ff[chunk_ff] || eff_map[slot_ff];
   assign map_empty = (eff_map == '0);
   assign new_map   = (op_ff == REQ_ALLOC) ? (eff_map & ~slot_mask) : (eff_map | slot_mask);
   assign push_head = to_full_ff ? fhead_ff : phead_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      chunk_in     = chunk_ff;
      slot_in      = slot_ff;
      claim_in     = claim_ff;
      phead_in     = phead_ff;
      fhead_in     = fhead_ff;
      used_in      = used_ff;
      to_full_in   = to_full_ff;
      old_head_in  = old_head_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      gchunk_in    = gchunk_ff;
      gslot_in     = gslot_ff;
      rel_in       = rel_ff;
      cmd          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = req_type;
               slot_in  = req_slot_index;
               claim_in = 1'b0;
               if (req_type == REQ_FREE) begin
                  chunk_in = req_chunk_index;
                  state_in = S_READ;
               end else if (phead_ff != NULL_LINK) begin
                  chunk_in = phead_ff[CHUNK_W-1:0];
                  state_in = S_READ;
               end else if (any_unused) begin
                  chunk_in = low_unused;
                  claim_in = 1'b1;
                  state_in = S_READ;
               end else begin
                  status_in    = ST_NO_CHUNK;
                  gchunk_in    = '0;
                  gslot_in     = '0;
                  rel_in       = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = chunk_in;
            end
         end
         S_READ: begin
            rel_in       = 1'b0;
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
            gchunk_in    = chunk_ff;
            gslot_in     = slot_ff;
            status_in    = ST_OK;
            if (op_ff == REQ_ALLOC && !map_found) begin
               status_in = ST_NO_CHUNK;
               gchunk_in = '0;
               gslot_in  = '0;
            end else if (op_ff == REQ_FREE && bad_free) begin
               status_in = ST_BAD_FREE;
            end else begin
               cmd.map_we   = 1'b1;
               cmd.map_addr = chunk_ff;
               cmd.map_data = new_map;
               if (op_ff == REQ_ALLOC) begin
                  gslot_in = first_bit;
               end
               if (op_ff == REQ_ALLOC && claim_ff) begin
                  // fresh chunk onto an empty partial list
                  used_in[chunk_ff] = 1'b1;
                  phead_in     = chunk_link;
                  cmd.nxt_we   = 1'b1;
                  cmd.nxt_addr = chunk_ff;
                  cmd.nxt_data = NULL_LINK;
                  cmd.prv_we   = 1'b1;
                  cmd.prv_addr = chunk_ff;
                  cmd.prv_data = NULL_LINK;
               end else if ((op_ff == REQ_ALLOC && new_map == '0)
                         || (op_ff == REQ_FREE && (map_empty || new_map == FULL_MASK))) begin
                  // unlink from the current list
                  if (rd.prv != NULL_LINK) begin
                     cmd.nxt_we   = 1'b1;
                     cmd.nxt_addr = rd.prv[CHUNK_W-1:0];
                     cmd.nxt_data = rd.nxt;
                  end
                  if (rd.nxt != NULL_LINK) begin
                     cmd.prv_we   = 1'b1;
                     cmd.prv_addr = rd.nxt[CHUNK_W-1:0];
                     cmd.prv_data = rd.prv;
                  end
                  if (op_ff == REQ_ALLOC || map_empty) begin
                     if (fhead_ff == chunk_link && op_ff == REQ_FREE) begin
                        fhead_in = rd.nxt;
                     end
                     if (phead_ff == chunk_link && op_ff == REQ_ALLOC) begin
                        phead_in = rd.nxt;
                     end
                  end else if (phead_ff == chunk_link) begin
                     phead_in = rd.nxt;
                  end
                  if (op_ff == REQ_FREE && new_map == FULL_MASK) begin
                     used_in[chunk_ff] = 1'b0;
                     rel_in = 1'b1;
                  end else begin
                     // hold the response until the chunk is pushed
                     to_full_in   = (op_ff == REQ_ALLOC);
                     rsp_valid_in = 1'b0;
                     state_in     = S_PUSH;
                  end
               end
            end
         end
         S_PUSH: begin
            cmd.nxt_we   = 1'b1;
            cmd.nxt_addr = chunk_ff;
            cmd.nxt_data = push_head;
            cmd.prv_we   = 1'b1;
            cmd.prv_addr = chunk_ff;
            cmd.prv_data = NULL_LINK;
            old_head_in  = push_head;
            if (to_full_ff) begin
               fhead_in = chunk_link;
            end else begin
               phead_in = chunk_link;
            end
            if (push_head != NULL_LINK) begin
               state_in = S_PUSH2;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_PUSH2: begin
            cmd.prv_we   = 1'b1;
            cmd.prv_addr = old_head_ff[CHUNK_W-1:0];
            cmd.prv_data = chunk_link;
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phead_ff     <= NULL_LINK;
         fhead_ff     <= NULL_LINK;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phead_ff     <= phead_in;
         fhead_ff     <= fhead_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      chunk_ff    <= chunk_in;
      slot_ff     <= slot_in;
      claim_ff    <= claim_in;
      to_full_ff  <= to_full_in;
      old_head_ff <= old_head_in;
      status_ff   <= status_in;
      gchunk_ff   <= gchunk_in;
      gslot_ff    <= gslot_in;
      rel_ff      <= rel_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_granted_chunk  = gchunk_ff;
   assign rsp_granted_slot   = gslot_ff;
   assign rsp_chunk_released = rel_ff;

`ifndef SYNTHESIS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NO_CHUNK
                     || rsp_status == ST_BAD_FREE))
      else $error("response status code out of range");
   a_phead_used: assert property (@(posedge clock) disable iff (reset)
      (phead_ff != NULL_LINK) |-> used_ff[phead_ff[CHUNK_W-1:0]])
      else $error("partial head names an unused chunk");
   a_fhead_used: assert property (@(posedge clock) disable iff (reset)
      (fhead_ff != NULL_LINK) |-> used_ff[fhead_ff[CHUNK_W-1:0]])
      else $error("full head names an unused chunk");
   a_heads_apart: assert property (@(posedge clock) disable iff (reset)
      (phead_ff != NULL_LINK) |-> (phead_ff != fhead_ff))
      else $error("chunk heads both lists");
   a_accept_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !rsp_valid)
      else $error("request taken while a response waits");
`endif

endmodule

// ===== hw/rtl/slab_bitmap_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// slab_bitmap_slot_allocator_core
// Slab slot allocator with per-chunk free bitmaps and partial/full lists.
// ----------------------------------------------------------------------------
// One request at a time. A request is taken in one cycle, the chunk's bitmap
// and links are read from memory in the next; the response is registered in
// S_READ or, when a chunk moves onto the other list, in S_PUSH, or in S_PUSH2
// if that list was not empty. An allocate with no chunk skips the read step.
// The response is held until taken; the next request is taken after that.
module slab_bitmap_slot_allocator_core
   import sbsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [CHUNK_W-1:0] req_chunk_index,
   input  logic [SLOT_W-1:0]  req_slot_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [CHUNK_W-1:0] rsp_granted_chunk,
   output logic [SLOT_W-1:0]  rsp_granted_slot,
   output logic               rsp_chunk_released
);

   mem_cmd_type cmd;
   mem_rd_type  rd;

   sbsa_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_chunk_index    (req_chunk_index),
      .req_slot_index     (req_slot_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_granted_chunk  (rsp_granted_chunk),
      .rsp_granted_slot   (rsp_granted_slot),
      .rsp_chunk_released (rsp_chunk_released),
      .cmd                (cmd),
      .rd                 (rd)
   );

   sbsa_store u_store (
      .clock (clock),
      .cmd   (cmd),
      .rd    (rd)
   );

endmodule
